/* rtl/core/pwa_pkg.sv */
// shared types and constants of the perspective warp address generator
// no dependencies
package pwa_pkg;

   localparam int unsigned NUM_COEF   = 8;
   localparam int unsigned SRC_WIDTH  = 188;
   localparam int unsigned SRC_HEIGHT = 120;
   localparam int unsigned QBITS      = 9;   // eight quotient bits plus overflow
   localparam int unsigned NUM_CELLS  = QBITS;

   localparam logic [3:0] IDX_XX = 4'd0;
   localparam logic [3:0] IDX_XY = 4'd1;
   localparam logic [3:0] IDX_XC = 4'd2;
   localparam logic [3:0] IDX_YX = 4'd3;
   localparam logic [3:0] IDX_YY = 4'd4;
   localparam logic [3:0] IDX_YC = 4'd5;
   localparam logic [3:0] IDX_WX = 4'd6;
   localparam logic [3:0] IDX_WY = 4'd7;

   localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

   typedef logic signed [NUM_COEF-1:0][31:0] coef_set_type;

   // reset coefficients, wy first down to xx: identity matrix, so each output pixel maps to twice its column and row
   localparam coef_set_type COEF_RESET = {32'd0, 32'd0, 32'd0, ONE_Q24,
                                          32'd0, 32'd0, 32'd0, ONE_Q24};

   // one item in flight through the divider row
   typedef struct packed {
      logic [41:0]      rem_c;
      logic [41:0]      rem_r;
      logic [49:0]      dsh;
      logic [QBITS-1:0] q_c;
      logic [QBITS-1:0] q_r;
      logic             neg_c;
      logic             neg_r;
      logic             zero;
   } div_type;

endpackage

/* rtl/core/perspective_warp_address.sv */
// top level of the perspective warp address generator
// depends on pwa_pkg, pwa_front and pwa_div_cell
//
// maps each output pixel (out_col, out_row) through a homography with
// Q8.24 coefficients and returns the source column, row and linear address
// plus an inside flag; outside or zero-denominator results carry zero data.
// one transaction is accepted per clock unless rsp_tready stalls the chain,
// which holds three front stages (multipliers, sums, magnitudes), nine divider
// cells of one quotient bit each (the top bit flags overflow) and one output
// register. every stage holds its own valid, so bubbles collapse and new
// transactions keep entering while a result waits on rsp_tready, until the chain
// is full. the user sees that coefficients are written on the csr port only while no
// transaction is in flight (not checked); an index of eight or above is ignored.
module perspective_warp_address
   import pwa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // out_col [6:0], out_row [13:7], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // src_col [7:0], src_row [14:8], src_addr [29:15], pad
   output logic [0:0]  rsp_tuser,   // inside_res [0]
   input  logic        csr_wen,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   coef_set_type coef_ff;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else if (csr_wen && (csr_index < 4'(NUM_COEF))) begin
         coef_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   // chain of divider cells, link 0 fed by the front end
   logic    link_valid [NUM_CELLS+1];
   logic    link_ready [NUM_CELLS+1];
   div_type link_item  [NUM_CELLS+1];

   pwa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_col   (req_tdata[6:0]),
      .out_row   (req_tdata[13:7]),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_item  (link_item[0])
   );

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      pwa_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_item   (link_item[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_item  (link_item[g+1])
      );
   end

   // output stage: range check and address
   div_type     fin;
   logic        ok_c, ok_r, inside_in;
   logic [7:0]  col_in;
   logic [6:0]  row_in;
   logic [14:0] addr_in;
   logic        rsp_valid_ff;
   logic [29:0] data_ff;
   logic        inside_ff;
   logic        take;

   assign fin  = link_item[NUM_CELLS];
   assign take = !rsp_valid_ff || rsp_tready;
   assign link_ready[NUM_CELLS] = take;

   always_comb begin
      // a negative quotient only passes when it truncates to zero
      ok_c = !fin.q_c[QBITS-1] && (!fin.neg_c || fin.q_c == '0)
             && ({1'b0, fin.q_c} < 10'(SRC_WIDTH));
      ok_r = !fin.q_r[QBITS-1] && (!fin.neg_r || fin.q_r == '0)
             && ({1'b0, fin.q_r} < 10'(SRC_HEIGHT));
      inside_in = !fin.zero && ok_c && ok_r;
      col_in  = inside_in ? fin.q_c[7:0] : 8'd0;
      row_in  = inside_in ? fin.q_r[6:0] : 7'd0;
      addr_in = 15'(({8'd0, row_in} * 15'(SRC_WIDTH)) + {7'd0, col_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= link_valid[NUM_CELLS];
      end
      if (take) begin
         data_ff   <= {addr_in, row_in, col_in};
         inside_ff <= inside_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {2'b00, data_ff};
   assign rsp_tuser[0] = inside_ff;

   // outside results carry zero data
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 32'd0))
      else $error("outside result with nonzero data");

   // inside results lie in the source frame
   a_inside_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         ((rsp_tdata[7:0] < 8'(SRC_WIDTH)) && (rsp_tdata[14:8] < 7'(SRC_HEIGHT))))
      else $error("inside result out of frame");

   // address agrees with column and row
   a_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[29:15] ==
         15'(({8'd0, rsp_tdata[14:8]} * 15'(SRC_WIDTH)) + {7'd0, rsp_tdata[7:0]})))
      else $error("address mismatch");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

/* rtl/core/pwa_front.sv */
// front end: products, sums and magnitudes of the two numerators and the denominator
// depends on pwa_pkg
module pwa_front
   import pwa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  coef_set_type coef,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [6:0]   out_col,
   input  logic [6:0]   out_row,
   output logic         out_valid,
   input  logic         out_ready,
   output div_type      out_item
);

   logic v1_ff, v2_ff, v3_ff;
   logic r1, r2, r3;
   logic signed [40:0] p_ff [6];
   logic signed [40:0] p_in [6];
   logic signed [41:0] nx_ff, ny_ff, d_ff;
   logic signed [41:0] nx_in, ny_in, d_in;
   div_type item_ff, item_in;
   logic signed [8:0] xs, ys;
   logic [41:0] mag_d;

   assign r3 = !v3_ff || out_ready;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;

   assign xs = $signed({1'b0, out_col, 1'b0});
   assign ys = $signed({1'b0, out_row, 1'b0});

   always_comb begin
      p_in[0] = $signed(coef[IDX_XX[2:0]]) * xs;
      p_in[1] = $signed(coef[IDX_XY[2:0]]) * ys;
      p_in[2] = $signed(coef[IDX_YX[2:0]]) * xs;
      p_in[3] = $signed(coef[IDX_YY[2:0]]) * ys;
      p_in[4] = $signed(coef[IDX_WX[2:0]]) * xs;
      p_in[5] = $signed(coef[IDX_WY[2:0]]) * ys;
      nx_in = 42'(p_ff[0]) + 42'(p_ff[1]) + 42'($signed(coef[IDX_XC[2:0]]));
      ny_in = 42'(p_ff[2]) + 42'(p_ff[3]) + 42'($signed(coef[IDX_YC[2:0]]));
      d_in  = 42'(p_ff[4]) + 42'(p_ff[5]) + 42'(ONE_Q24);
      mag_d = d_ff[41] ? 42'(-d_ff) : 42'(d_ff);
      item_in.rem_c = nx_ff[41] ? 42'(-nx_ff) : 42'(nx_ff);
      item_in.rem_r = ny_ff[41] ? 42'(-ny_ff) : 42'(ny_ff);
      item_in.dsh   = {mag_d, 8'd0};
      item_in.q_c   = '0;
      item_in.q_r   = '0;
      item_in.neg_c = nx_ff[41] ^ d_ff[41];
      item_in.neg_r = ny_ff[41] ^ d_ff[41];
      item_in.zero  = (d_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
      end
      if (r1) begin
         for (int k = 0; k < 6; k++) p_ff[k] <= p_in[k];
      end
      if (r2) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         d_ff  <= d_in;
      end
      if (r3) item_ff <= item_in;
   end

   assign out_valid = v3_ff;
   assign out_item  = item_ff;

endmodule

/* rtl/core/pwa_div_cell.sv */
// one restoring division step for both the column and the row quotient
// depends on pwa_pkg
module pwa_div_cell
   import pwa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_item,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_item
);

   logic    v_ff;
   div_type item_ff, item_in;
   logic    ge_c, ge_r;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      ge_c = {8'd0, in_item.rem_c} >= in_item.dsh;
      ge_r = {8'd0, in_item.rem_r} >= in_item.dsh;
      item_in       = in_item;
      item_in.rem_c = ge_c ? in_item.rem_c - in_item.dsh[41:0] : in_item.rem_c;
      item_in.rem_r = ge_r ? in_item.rem_r - in_item.dsh[41:0] : in_item.rem_r;
      item_in.dsh   = in_item.dsh >> 1;
      item_in.q_c   = {in_item.q_c[QBITS-2:0], ge_c};
      item_in.q_r   = {in_item.q_r[QBITS-2:0], ge_r};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
      if (in_ready) item_ff <= item_in;
   end

   assign out_valid = v_ff;
   assign out_item  = item_ff;

endmodule
